// ===== hw/rtl/sbae_pkg.sv =====
`default_nettype none

package sbae_pkg;

  localparam int DEF_CAPACITY    = 256;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [3:0] MODE_PUSH         = 4'd0;
  localparam logic [3:0] MODE_POP          = 4'd1;
  localparam logic [3:0] MODE_TOP          = 4'd2;
  localparam logic [3:0] MODE_GET          = 4'd3;
  localparam logic [3:0] MODE_PUT          = 4'd4;
  localparam logic [3:0] MODE_SWAP         = 4'd5;
  localparam logic [3:0] MODE_REMOVE_AT    = 4'd6;
  localparam logic [3:0] MODE_CONTAINS     = 4'd7;
  localparam logic [3:0] MODE_REMOVE_VALUE = 4'd8;

  typedef enum logic [3:0] {
    OP_PUSH,
    OP_POP,
    OP_TOP,
    OP_GET,
    OP_PUT,
    OP_SWAP,
    OP_REMOVE_AT,
    OP_CONTAINS,
    OP_REMOVE_VALUE,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] pos;
    logic [7:0] pos2;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_EXEC,
    BK_READ,
    BK_SWAP_A,
    BK_SWAP_B,
    BK_SWAP_W,
    BK_SHIFT_RD,
    BK_SHIFT_WR,
    BK_SCAN_RD,
    BK_SCAN_CMP
  } back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbae_front.sv =====
`default_nettype none

module sbae_front #(
  parameter int VALUE_WIDTH = sbae_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                    start,
  input  wire logic                    q_full,
  input  wire logic [3:0]              in_mode,
  input  wire logic [7:0]              in_position,
  input  wire logic [7:0]              in_second_position,
  input  wire logic signed [31:0]      in_value,
  output sbae_pkg::cmd_t               cmd,
  output logic [VALUE_WIDTH-1:0]       cmd_value,
  output logic                         q_push
);
  import sbae_pkg::*;

  localparam int EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  logic [EXT_W-1:0] value_ext;

  assign q_push    = start && !q_full;
  assign value_ext = EXT_W'(in_value);
  assign cmd_value = value_ext[VALUE_WIDTH-1:0];

  always_comb begin
    cmd.pos  = in_position;
    cmd.pos2 = in_second_position;
    unique case (in_mode)
      MODE_PUSH:         cmd.op = OP_PUSH;
      MODE_POP:          cmd.op = OP_POP;
      MODE_TOP:          cmd.op = OP_TOP;
      MODE_GET:          cmd.op = OP_GET;
      MODE_PUT:          cmd.op = OP_PUT;
      MODE_SWAP:         cmd.op = OP_SWAP;
      MODE_REMOVE_AT:    cmd.op = OP_REMOVE_AT;
      MODE_CONTAINS:     cmd.op = OP_CONTAINS;
      MODE_REMOVE_VALUE: cmd.op = OP_REMOVE_VALUE;
      default:           cmd.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbae_queue.sv =====
`default_nettype none

module sbae_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = sbae_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      rdata,
  output logic                   full,
  output logic                   empty
);
  import sbae_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full    = (fill_r == CNT_W'(DEPTH));
  assign empty   = (fill_r == '0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbae_back.sv =====
`default_nettype none

module sbae_back #(
  parameter int CAPACITY    = sbae_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = sbae_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  input  wire sbae_pkg::cmd_t         q_cmd,
  input  wire logic [VALUE_WIDTH-1:0] q_value,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic signed [31:0]          out_read_value,
  output logic                        out_found,
  output logic [8:0]                  out_item_count,
  output logic                        out_is_empty,
  output logic [1:0]                  out_status
);
  import sbae_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int PW    = (CW > 8) ? CW : 8;
  localparam int EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int CXW   = (CW > 9) ? CW : 9;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata_r;

  back_state_t            state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [VALUE_WIDTH-1:0] tmp_r, tmp_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   found_r, found_nxt;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;

  logic                   done;
  status_t                done_status;
  logic [VALUE_WIDTH-1:0] done_read;

  logic                   empty;
  logic                   pos_bad, pos2_bad;
  logic [CW-1:0]          count_m1, idx_p1;

  logic                   out_valid_r;
  logic [EXT_W-1:0]       read_ext_r;
  logic                   out_found_r;
  logic [CXW-1:0]         count_ext_r;
  logic                   out_is_empty_r;
  status_t                out_status_r;

  assign empty    = (count_r == '0);
  assign pos_bad  = (PW'(cmd_r.pos) >= PW'(count_r));
  assign pos2_bad = (PW'(cmd_r.pos2) >= PW'(count_r));
  assign count_m1 = count_r - 1'b1;
  assign idx_p1   = idx_r + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    val_nxt     = val_r;
    tmp_nxt     = tmp_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    done        = 1'b0;
    done_status = ST_OK;
    done_read   = '0;

    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          val_nxt   = q_value;
          found_nxt = 1'b0;
          state_nxt = BK_EXEC;
        end
      end

      BK_EXEC: begin
        priority if (cmd_r.op != OP_PUSH && cmd_r.op != OP_NOP && empty) begin
          done        = 1'b1;
          done_status = ST_EMPTY;
        end else begin
          unique case (cmd_r.op)
            OP_PUSH: begin
              done = 1'b1;
              if (count_r == CW'(CAPACITY)) begin
                done_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = val_r;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP: begin
              done      = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = count_m1[AW-1:0];
              count_nxt = count_m1;
            end
            OP_TOP: begin
              mem_raddr = count_m1[AW-1:0];
              state_nxt = BK_READ;
            end
            OP_GET: begin
              if (pos_bad) begin
                done        = 1'b1;
                done_status = ST_RANGE;
              end else begin
                mem_raddr = AW'(cmd_r.pos);
                state_nxt = BK_READ;
              end
            end
            OP_PUT: begin
              done = 1'b1;
              if (pos_bad) begin
                done_status = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cmd_r.pos);
                mem_wdata = val_r;
              end
            end
            OP_SWAP: begin
              if (pos_bad || pos2_bad) begin
                done        = 1'b1;
                done_status = ST_RANGE;
              end else begin
                mem_raddr = AW'(cmd_r.pos);
                state_nxt = BK_SWAP_A;
              end
            end
            OP_REMOVE_AT: begin
              if (pos_bad) begin
                done        = 1'b1;
                done_status = ST_RANGE;
              end else begin
                idx_nxt   = CW'(cmd_r.pos);
                state_nxt = BK_SHIFT_RD;
              end
            end
            OP_CONTAINS, OP_REMOVE_VALUE: begin
              idx_nxt   = '0;
              state_nxt = BK_SCAN_RD;
            end
            OP_NOP: begin
              done = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      BK_READ: begin
        done      = 1'b1;
        done_read = rdata_r;
      end

      BK_SWAP_A: begin
        tmp_nxt   = rdata_r;
        mem_raddr = AW'(cmd_r.pos2);
        state_nxt = BK_SWAP_B;
      end

      BK_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cmd_r.pos);
        mem_wdata = rdata_r;
        state_nxt = BK_SWAP_W;
      end

      BK_SWAP_W: begin
        done      = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = AW'(cmd_r.pos2);
        mem_wdata = tmp_r;
      end

      // move one entry down per read state and write state pair, old last entry left in place
      BK_SHIFT_RD: begin
        if (idx_p1 < count_r) begin
          mem_raddr = idx_p1[AW-1:0];
          state_nxt = BK_SHIFT_WR;
        end else begin
          done      = 1'b1;
          count_nxt = count_m1;
        end
      end

      BK_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = rdata_r;
        idx_nxt   = idx_p1;
        state_nxt = BK_SHIFT_RD;
      end

      BK_SCAN_RD: begin
        if (idx_r < count_r) begin
          mem_raddr = idx_r[AW-1:0];
          state_nxt = BK_SCAN_CMP;
        end else begin
          done = 1'b1;
        end
      end

      BK_SCAN_CMP: begin
        if (rdata_r == val_r) begin
          found_nxt = 1'b1;
          if (cmd_r.op == OP_REMOVE_VALUE) begin
            state_nxt = BK_SHIFT_RD;
          end else begin
            done = 1'b1;
          end
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = BK_SCAN_RD;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = BK_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
    tmp_r <= tmp_nxt;
    idx_r <= idx_nxt;
    if (done) begin
      read_ext_r     <= EXT_W'($signed(done_read));
      out_found_r    <= found_nxt;
      count_ext_r    <= CXW'(count_nxt);
      out_is_empty_r <= (count_nxt == '0);
      out_status_r   <= done_status;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = read_ext_r[31:0];
  assign out_found      = out_found_r;
  assign out_item_count = count_ext_r[8:0];
  assign out_is_empty   = out_is_empty_r;
  assign out_status     = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r != BK_IDLE)
    else $error("store written while idle");

  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != count_nxt |=> out_valid_r)
    else $error("count changed without a result");

endmodule

`default_nettype wire

// ===== hw/rtl/stack_bag_array_engine_unit.sv =====
// Array-backed stack and bag of CAPACITY entries with a command interface. An item is
// taken when start is high and busy is low; busy rises only while the two-entry command
// queue is full. Each item gives exactly one result, shown for one cycle with out_valid
// high, and the receiver cannot stall it. All work is done by one engine behind the
// queue with a single-port-read store (one write and one registered read per cycle).
// Order of work, once the engine is idle: push, pop, put, errors and undefined modes finish
// in the execute state; top and get add a read state; swap reads both entries and then
// writes both; contains walks the items up to the match; removals shift the later
// entries down one at a time, so a removal near the bottom of a full store moves
// nearly every entry.
// Items are taken back to back into the queue while the engine works, unless it is full.
`default_nettype none

module stack_bag_array_engine_unit #(
  parameter int CAPACITY    = sbae_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = sbae_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         in_mode,
  input  wire logic [7:0]         in_position,
  input  wire logic [7:0]         in_second_position,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  output logic signed [31:0]      out_read_value,
  output logic                    out_found,
  output logic [8:0]              out_item_count,
  output logic                    out_is_empty,
  output logic [1:0]              out_status
);
  import sbae_pkg::*;

  localparam int Q_W = $bits(cmd_t) + VALUE_WIDTH;

  cmd_t                   front_cmd, head_cmd;
  logic [VALUE_WIDTH-1:0] front_value, head_value;
  logic                   q_push, q_pop, q_full, q_empty;
  logic [Q_W-1:0]         q_head;

  assign busy = q_full;

  sbae_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .start              (start),
    .q_full             (q_full),
    .in_mode            (in_mode),
    .in_position        (in_position),
    .in_second_position (in_second_position),
    .in_value           (in_value),
    .cmd                (front_cmd),
    .cmd_value          (front_value),
    .q_push             (q_push)
  );

  sbae_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({front_cmd, front_value}),
    .pop   (q_pop),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {head_cmd, head_value} = q_head;

  sbae_back #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (head_cmd),
    .q_value        (head_value),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_found      (out_found),
    .out_item_count (out_item_count),
    .out_is_empty   (out_is_empty),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire
